[rtl/marker_visit_steering_defines.svh]
// ----------------------------------------------------------------------------
// marker_visit_steering assertion macros
// shared concurrent assertion forms for the steering block
// ----------------------------------------------------------------------------
`ifndef MARKER_VISIT_STEERING_DEFINES_SVH
`define MARKER_VISIT_STEERING_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("marker_visit_steering: assertion failed");

// next-cycle implication, disabled during reset
`define MVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("marker_visit_steering: assertion failed");

`endif

[rtl/mvs_pkg.sv]
// ----------------------------------------------------------------------------
// mvs_pkg
// types and constants of the marker visit steering block
// ----------------------------------------------------------------------------
package mvs_pkg;

    localparam int ID_W     = 10;
    localparam int SEEN_W   = 11;
    localparam int PIX_W    = 12;
    localparam int AREA_W   = 25;
    localparam int THR_W    = 24;
    localparam int MILLI_W  = 10;
    localparam int LIN_W    = 10;
    localparam int ANG_W    = 11;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 5;
    localparam int IN_W     = 64;
    localparam int OUT_W    = 32;

    localparam logic signed [LIN_W-1:0] SEARCH_LIN   = -10'sd500;
    localparam logic signed [LIN_W-1:0] CREEP_LIN    = 10'sd250;
    localparam logic signed [ANG_W-1:0] SEARCH_ANG   = 11'sd500;
    localparam logic [IDX_W-1:0]        LAST_INDEX   = 3'd4;

    localparam logic [ID_W-1:0]    RST_ID_A      = 10'd11;
    localparam logic [ID_W-1:0]    RST_ID_B      = 10'd12;
    localparam logic [ID_W-1:0]    RST_ID_C      = 10'd13;
    localparam logic [ID_W-1:0]    RST_ID_D      = 10'd15;
    localparam logic [THR_W-1:0]   RST_AREA_THR  = 24'd20000;
    localparam logic [PIX_W-1:0]   RST_MISALIGN  = 12'd150;
    localparam logic [MILLI_W-1:0] RST_GAIN      = 10'd10;
    localparam logic [MILLI_W-1:0] RST_CAP       = 10'd500;

    typedef enum logic [2:0] {
        CFG_TARGET_A = 3'd0,
        CFG_TARGET_B = 3'd1,
        CFG_TARGET_C = 3'd2,
        CFG_TARGET_D = 3'd3,
        CFG_AREA_THR = 3'd4,
        CFG_MISALIGN = 3'd5,
        CFG_GAIN     = 3'd6,
        CFG_CAP      = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [AREA_W-1:0]        marker_area;
        logic [PIX_W-1:0]         image_width;
        logic [PIX_W-1:0]         centre_x;
        logic signed [SEEN_W-1:0] seen_id;
    } t_report;

    typedef struct packed {
        logic                     mission_done;
        logic [IDX_W-1:0]         visited_count;
        logic                     approaching;
        logic signed [ANG_W-1:0]  angular_milli;
        logic signed [LIN_W-1:0]  linear_milli;
    } t_command;

endpackage

[rtl/marker_visit_steering.sv]
// ----------------------------------------------------------------------------
// marker_visit_steering
// steering for a robot that visits four configured markers in turn
// ----------------------------------------------------------------------------
// one camera report beat on the s_axis side gives one velocity command beat
// on the m_axis side, in order. a report is latched into an input register,
// and once the output register is free the steering step runs against the
// mission state and its command lands in the output register. one report
// can be taken every cycle while m_axis_tready is high: the state update is
// a single short step between the two registers and the only arithmetic is
// one 10 x 13 bit multiply for the proportional turn.
// when m_axis_tready is low the command holds in the output register and the
// input register still takes one more report; s_axis_tready drops only when
// both are full. the apb port writes the marker ids and the steering limits;
// the user must do so only while the block is idle, which the block itself
// does not enforce. pready is always high.
// reset clears the mission (index 0, no approach, not done, last turn left),
// restores the default register values and empties both registers.
// ----------------------------------------------------------------------------
`include "marker_visit_steering_defines.svh"

module marker_visit_steering
    import mvs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // report: seen_id[10:0], centre_x[22:11], image_width[34:23],
    // marker_area[59:35], zero[63:60]
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,
    // command: linear_milli[9:0], angular_milli[20:10], approaching[21],
    // visited_count[24:22], mission_done[25], zero[31:26]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // configuration
    logic [ID_W-1:0]    r_id_a, r_id_b, r_id_c, r_id_d;
    logic [THR_W-1:0]   r_area_thr;
    logic [PIX_W-1:0]   r_misalign;
    logic [MILLI_W-1:0] r_gain;
    logic [MILLI_W-1:0] r_cap;

    // mission state
    logic [IDX_W-1:0]   r_index, n_index;
    logic               r_approach, n_approach;
    logic               r_done, n_done;
    logic               r_left, n_left;

    // pipeline
    logic               r_in_valid;
    t_report            r_in;
    logic               r_out_valid;
    t_command           r_out, n_out;

    logic               cfg_wr;
    t_cfg_reg           cfg_sel;
    logic               out_free;
    logic               advance;

    // step datapath
    logic [ID_W-1:0]          target;
    logic                     seen_neg;
    logic                     seen_known;
    logic                     seen_target;
    logic signed [PIX_W+1:0]  d;
    logic [PIX_W:0]           ad;
    logic                     d_pos;
    logic [MILLI_W+PIX_W:0]   prod;
    logic [MILLI_W+PIX_W-1:0] spd_full;
    logic [MILLI_W-1:0]       spd;
    logic signed [ANG_W-1:0]  search_ang;
    logic                     reached;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_sel = t_cfg_reg'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_a     <= RST_ID_A;
            r_id_b     <= RST_ID_B;
            r_id_c     <= RST_ID_C;
            r_id_d     <= RST_ID_D;
            r_area_thr <= RST_AREA_THR;
            r_misalign <= RST_MISALIGN;
            r_gain     <= RST_GAIN;
            r_cap      <= RST_CAP;
        end else if (cfg_wr) begin
            case (cfg_sel)
                CFG_TARGET_A: r_id_a     <= pwdata[ID_W-1:0];
                CFG_TARGET_B: r_id_b     <= pwdata[ID_W-1:0];
                CFG_TARGET_C: r_id_c     <= pwdata[ID_W-1:0];
                CFG_TARGET_D: r_id_d     <= pwdata[ID_W-1:0];
                CFG_AREA_THR: r_area_thr <= pwdata[THR_W-1:0];
                CFG_MISALIGN: r_misalign <= pwdata[PIX_W-1:0];
                CFG_GAIN:     r_gain     <= pwdata[MILLI_W-1:0];
                CFG_CAP:      r_cap      <= pwdata[MILLI_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            CFG_TARGET_A: prdata = {{(32-ID_W){1'b0}}, r_id_a};
            CFG_TARGET_B: prdata = {{(32-ID_W){1'b0}}, r_id_b};
            CFG_TARGET_C: prdata = {{(32-ID_W){1'b0}}, r_id_c};
            CFG_TARGET_D: prdata = {{(32-ID_W){1'b0}}, r_id_d};
            CFG_AREA_THR: prdata = {{(32-THR_W){1'b0}}, r_area_thr};
            CFG_MISALIGN: prdata = {{(32-PIX_W){1'b0}}, r_misalign};
            CFG_GAIN:     prdata = {{(32-MILLI_W){1'b0}}, r_gain};
            CFG_CAP:      prdata = {{(32-MILLI_W){1'b0}}, r_cap};
            default:      prdata = '0;
        endcase
    end

    // handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_W-$bits(t_command)){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= t_report'(s_axis_tdata[$bits(t_report)-1:0]);
        end
    end

    // id match and target lookup
    always_comb begin
        case (r_index[1:0])
            2'd0:    target = r_id_a;
            2'd1:    target = r_id_b;
            2'd2:    target = r_id_c;
            default: target = r_id_d;
        endcase
    end

    assign seen_neg    = r_in.seen_id[SEEN_W-1];
    assign seen_known  = !seen_neg &&
                         (r_in.seen_id[ID_W-1:0] == r_id_a ||
                          r_in.seen_id[ID_W-1:0] == r_id_b ||
                          r_in.seen_id[ID_W-1:0] == r_id_c ||
                          r_in.seen_id[ID_W-1:0] == r_id_d);
    assign seen_target = seen_known && (r_in.seen_id[ID_W-1:0] == target);
    assign search_ang  = r_left ? SEARCH_ANG : -SEARCH_ANG;

    // doubled misalignment and capped proportional turn
    assign d        = $signed({1'b0, r_in.centre_x, 1'b0}) - $signed({2'b00, r_in.image_width});
    assign ad       = d[PIX_W+1] ? -d[PIX_W:0] : d[PIX_W:0];
    assign d_pos    = !d[PIX_W+1] && (d != '0);
    assign prod     = r_gain * ad;
    assign spd_full = prod[MILLI_W+PIX_W:1];
    assign spd      = (spd_full > {{PIX_W{1'b0}}, r_cap}) ? r_cap : spd_full[MILLI_W-1:0];

    assign reached  = !r_in.marker_area[AREA_W-1] &&
                      (r_in.marker_area[THR_W-1:0] > r_area_thr);

    always_comb begin
        n_index    = r_index;
        n_approach = r_approach;
        n_done     = r_done;
        n_left     = r_left;
        n_out      = '0;
        if (!r_done) begin
            if (seen_neg) begin
                n_out.angular_milli = search_ang;
            end else if (seen_known) begin
                if (seen_target) begin
                    n_approach = 1'b1;
                end else begin
                    n_out.angular_milli = search_ang;
                end
            end else begin
                n_out.linear_milli = SEARCH_LIN;
            end

            if (n_approach) begin
                if (reached) begin
                    n_index    = r_index + 3'd1;
                    n_done     = (n_index == LAST_INDEX);
                    n_approach = 1'b0;
                end else if (r_in.marker_area[AREA_W-1]) begin
                    n_approach = 1'b0;
                end

                if (ad > {r_misalign, 1'b0}) begin
                    n_out.linear_milli = '0;
                    if (d_pos) begin
                        n_left              = 1'b0;
                        n_out.angular_milli = -$signed({1'b0, spd});
                    end else begin
                        n_left              = 1'b1;
                        n_out.angular_milli = $signed({1'b0, spd});
                    end
                end else begin
                    n_out.linear_milli  = CREEP_LIN;
                    n_out.angular_milli = '0;
                end
            end
        end
        n_out.approaching   = n_approach;
        n_out.visited_count = n_index;
        n_out.mission_done  = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_approach  <= 1'b0;
            r_done      <= 1'b0;
            r_left      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_index    <= n_index;
                r_approach <= n_approach;
                r_done     <= n_done;
                r_left     <= n_left;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    `MVS_ASSERT_NOW(a_done_at_last, i_clk, i_rst_n, 1'b1, r_done == (r_index == LAST_INDEX))
    `MVS_ASSERT_NOW(a_no_approach_done, i_clk, i_rst_n, r_done, !r_approach)
    `MVS_ASSERT_NEXT(a_done_frozen, i_clk, i_rst_n, r_done, r_done && $stable(r_index))
    `MVS_ASSERT_NEXT(a_stall_no_step, i_clk, i_rst_n, r_out_valid && !m_axis_tready, $stable(r_index) && $stable(r_approach))

endmodule
